/* sv/sbs_pkg.sv */
// sorted breakpoint set: shared types and constants
// no dependencies; imported by sbs_cell and sorted_breakpoint_set_top
package sbs_pkg;

  localparam int unsigned SetDepth = 32;
  localparam int unsigned KeyBits  = 13;
  localparam int unsigned CntBits  = $clog2(SetDepth + 1);
  localparam int unsigned StatBits = 3;

  typedef enum logic {
    FUNC_TOGGLE = 1'b0,
    FUNC_CHECK  = 1'b1
  } sbs_func_e;

  typedef enum logic [StatBits-1:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } sbs_status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } sbs_op_e;

  typedef struct packed {
    sbs_func_e          func;
    logic [KeyBits-1:0] key_row;
  } sbs_in_t;

  typedef struct packed {
    sbs_status_e        status;
    logic [CntBits-1:0] entries_held;
  } sbs_out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    sbs_op_e            op;
    logic [KeyBits-1:0] key;
  } sbs_ctrl_t;

  // compare flags a cell reports about its own key
  typedef struct packed {
    logic lt;
    logic eq;
  } sbs_flags_t;

endpackage

/* sv/sbs_cell.sv */
// sorted breakpoint set: one cell of the sorted key chain
// depends on sbs_pkg
module sbs_cell (
  input  logic                      clk_i,
  input  sbs_pkg::sbs_ctrl_t        ctrl_i,
  input  logic                      valid_i,
  input  logic                      prev_lt_i,
  input  logic [sbs_pkg::KeyBits-1:0] prev_key_i,
  input  logic [sbs_pkg::KeyBits-1:0] next_key_i,
  output logic [sbs_pkg::KeyBits-1:0] key_o,
  output sbs_pkg::sbs_flags_t       flags_o
);
  import sbs_pkg::*;

  logic [KeyBits-1:0] key_q, key_d;

  // an empty cell counts as larger than any key
  assign flags_o.lt = valid_i && (key_q < ctrl_i.key);
  assign flags_o.eq = valid_i && (key_q == ctrl_i.key);
  assign key_o      = key_q;

  always_comb begin
    key_d = key_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (!flags_o.lt) begin
          key_d = prev_lt_i ? ctrl_i.key : prev_key_i;
        end
      end
      OP_DELETE: begin
        if (!flags_o.lt) begin
          key_d = next_key_i;
        end
      end
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

/* sv/sorted_breakpoint_set_top.sv */
// sorted breakpoint set: top level, chain of key cells plus count and result register
// depends on sbs_pkg and sbs_cell
//
// usage
//   command channel: an item (func, key_row) on req_i is taken at a rising
//   edge with start high and busy low. busy stays low, so a new item may be
//   issued every cycle.
//   result channel: one beat per item on result_o, marked by result_valid_o
//   for exactly one cycle, the cycle right after the item was taken. the
//   receiver cannot stall; each beat must be taken in that cycle.
//   throughput is one item per cycle: every cell compares its key against
//   the broadcast key in parallel and the whole chain shifts up (insert)
//   or down (delete) at the edge that takes the item.
//   toggle deletes a present key, inserts an absent one in order, and is
//   refused with a full status when the set is full and the key is absent.
//   check reports hit or miss and leaves the set untouched.
//   reset clears the key count and the result strobe; cell contents are
//   left as they are, since keys at or past the count never reach a result.
module sorted_breakpoint_set_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sbs_pkg::sbs_in_t  req_i,
  output logic              result_valid_o,
  output sbs_pkg::sbs_out_t result_o
);
  import sbs_pkg::*;

  logic                         accept;
  sbs_ctrl_t                    ctrl;
  logic [SetDepth-1:0]          valid;
  logic [SetDepth-1:0]          lt_vec;
  logic [SetDepth-1:0]          eq_vec;
  logic [KeyBits-1:0]           keys [SetDepth];
  logic                         found;
  logic                         full;
  logic [CntBits-1:0]           count_q, count_d;
  logic                         strobe_q;
  sbs_out_t                     out_q, out_d;

  // never holds off a command
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // occupancy follows the count: cells below it hold live keys
  always_comb begin
    for (int i = 0; i < SetDepth; i++) begin
      valid[i] = (CntBits'(i) < count_q);
    end
  end

  assign found = |eq_vec;
  assign full  = (count_q == CntBits'(SetDepth));

  // pick the operation the chain performs this cycle and the result beat
  always_comb begin
    ctrl.key         = req_i.key_row;
    ctrl.op          = OP_HOLD;
    count_d          = count_q;
    out_d.status     = ST_MISS;
    out_d.entries_held = count_q;
    if (req_i.func == FUNC_CHECK) begin
      out_d.status = found ? ST_HIT : ST_MISS;
    end else if (found) begin
      ctrl.op      = OP_DELETE;
      count_d      = count_q - CntBits'(1);
      out_d.status = ST_DELETED;
    end else if (full) begin
      out_d.status = ST_FULL;
    end else begin
      ctrl.op      = OP_INSERT;
      count_d      = count_q + CntBits'(1);
      out_d.status = ST_INSERTED;
    end
    out_d.entries_held = count_d;
    if (!accept) begin
      ctrl.op = OP_HOLD;
      count_d = count_q;
    end
  end

  // the cell chain: each cell sees its lower neighbor's compare and both neighbors' keys
  for (genvar g = 0; g < SetDepth; g++) begin : g_cell
    sbs_flags_t         flags;
    logic               prev_lt;
    logic [KeyBits-1:0] prev_key;
    logic [KeyBits-1:0] next_key;

    if (g == 0) begin : g_head
      // the head cell takes the new key whenever it is not below it
      assign prev_lt  = 1'b1;
      assign prev_key = keys[g];
    end else begin : g_mid
      assign prev_lt  = lt_vec[g-1];
      assign prev_key = keys[g-1];
    end

    if (g == SetDepth - 1) begin : g_tail
      // the tail cell keeps its own key on a delete and lies past the count afterwards
      assign next_key = keys[g];
    end else begin : g_body
      assign next_key = keys[g+1];
    end

    sbs_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (valid[g]),
      .prev_lt_i  (prev_lt),
      .prev_key_i (prev_key),
      .next_key_i (next_key),
      .key_o      (keys[g]),
      .flags_o    (flags)
    );

    assign lt_vec[g] = flags.lt;
    assign eq_vec[g] = flags.eq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      strobe_q <= accept;
    end
  end

  // result payload, qualified by the strobe
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = strobe_q;
  assign result_o       = out_q;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// testbench for sorted_breakpoint_set_top: toggle and check commands against a sorted-set predictor
// depends on sbs_pkg and the sorted_breakpoint_set_top rtl
module tb_top;
  import sbs_pkg::*;

  localparam int unsigned KeyMax     = (1 << KeyBits) - 1;
  localparam int unsigned StallLimit = 200;   // cycles with no beat before giving up
  localparam int unsigned RandItems  = 1700;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  sbs_in_t  req_i;
  logic     result_valid_o;
  sbs_out_t result_o;

  sorted_breakpoint_set_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state: the keys in ascending order and how many are held
  logic [KeyBits-1:0] set_keys [SetDepth];
  int unsigned        set_count;

  // results still owed by the block, oldest first
  sbs_out_t pending_results [$];

  int unsigned mismatches;
  int unsigned stall_cycles;
  bit          quiet_stretch;   // suppresses random gaps on the command side

  // does the predicted set hold this key
  function automatic bit set_holds(logic [KeyBits-1:0] key);
    for (int unsigned i = 0; i < set_count; i++) begin
      if (set_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // applies one command to the predicted set and returns the beat it owes
  function automatic sbs_out_t apply_command(sbs_in_t cmd);
    int unsigned pos;
    bit          found;
    sbs_out_t    res;
    pos = 0;
    // first slot whose key is not below the command key
    while (pos < set_count && set_keys[pos] < cmd.key_row) pos++;
    found = (pos < set_count) && (set_keys[pos] == cmd.key_row);
    if (cmd.func == FUNC_CHECK) begin
      res.status = found ? ST_HIT : ST_MISS;
    end else if (found) begin
      // delete closes the gap, also on a full set
      for (int unsigned i = pos; i + 1 < set_count; i++) set_keys[i] = set_keys[i + 1];
      set_count--;
      res.status = ST_DELETED;
    end else if (set_count >= SetDepth) begin
      // absent key on a full set: refused, set untouched
      res.status = ST_FULL;
    end else begin
      for (int unsigned i = set_count; i > pos; i--) set_keys[i] = set_keys[i - 1];
      set_keys[pos] = cmd.key_row;
      set_count++;
      res.status = ST_INSERTED;
    end
    res.entries_held = CntBits'(set_count);
    return res;
  endfunction

  function automatic sbs_in_t make_cmd(sbs_func_e func, int unsigned key);
    sbs_in_t cmd;
    cmd.func    = func;
    cmd.key_row = KeyBits'(key);
    return cmd;
  endfunction

  // sends one command beat; entered and left at a falling edge, start left high
  task automatic issue_command(sbs_in_t cmd);
    if (!quiet_stretch && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy !== 1'b0);
    // taken at this edge: its beat is owed in the next cycle
    pending_results.push_back(apply_command(cmd));
    @(negedge clk_i);
  endtask

  // random key not currently in the set
  function automatic int unsigned absent_key();
    int unsigned key;
    do key = $urandom_range(KeyMax); while (set_holds(KeyBits'(key)));
    return key;
  endfunction

  // result side: every strobed beat must match the oldest owed beat
  always @(posedge clk_i) begin : check_results
    sbs_out_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing owed, status %0d entries %0d",
                 $time, result_o.status, result_o.entries_held);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, result_o.status);
          mismatches++;
        end
        if (result_o.entries_held !== want.entries_held) begin
          $display("%0t: entries_held expected %0d actual %0d",
                   $time, want.entries_held, result_o.entries_held);
          mismatches++;
        end
      end
    end
  end

  // watchdog: counts cycles in which no beat moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start === 1'b1 && busy === 1'b0) || result_valid_o === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("[sorted_breakpoint_set_top] ERROR");
      $finish;
    end
  end

  // extremes of the key, every bit both ways, insert/delete at either end and in the middle
  task automatic test_directed();
    issue_command(make_cmd(FUNC_CHECK, 0));          // check on an empty set
    issue_command(make_cmd(FUNC_TOGGLE, KeyMax));
    issue_command(make_cmd(FUNC_TOGGLE, 0));
    issue_command(make_cmd(FUNC_TOGGLE, 4096));
    issue_command(make_cmd(FUNC_TOGGLE, 4095));
    issue_command(make_cmd(FUNC_TOGGLE, 1));
    issue_command(make_cmd(FUNC_CHECK, KeyMax));
    issue_command(make_cmd(FUNC_CHECK, 0));
    issue_command(make_cmd(FUNC_CHECK, 2));
    issue_command(make_cmd(FUNC_TOGGLE, 4096));      // delete from the middle
    issue_command(make_cmd(FUNC_TOGGLE, 0));         // delete the lowest
    issue_command(make_cmd(FUNC_TOGGLE, KeyMax));    // delete the highest
    issue_command(make_cmd(FUNC_CHECK, 4096));
    issue_command(make_cmd(FUNC_TOGGLE, 1));
    issue_command(make_cmd(FUNC_TOGGLE, 4095));      // back to empty
    issue_command(make_cmd(FUNC_TOGGLE, 'h1555));
    issue_command(make_cmd(FUNC_TOGGLE, 'h0aaa));
    issue_command(make_cmd(FUNC_CHECK, 'h1555));
    issue_command(make_cmd(FUNC_CHECK, 'h0aaa));
    issue_command(make_cmd(FUNC_TOGGLE, 'h1555));
    issue_command(make_cmd(FUNC_TOGGLE, 'h0aaa));
  endtask

  // fill to capacity, refuse an insert, delete while full at both ends, then drain
  task automatic test_full_set();
    int unsigned key;
    while (set_count < SetDepth) issue_command(make_cmd(FUNC_TOGGLE, absent_key()));
    issue_command(make_cmd(FUNC_TOGGLE, absent_key()));          // refused
    issue_command(make_cmd(FUNC_CHECK, 32'(set_keys[SetDepth - 1])));
    key = 32'(set_keys[$urandom_range(SetDepth - 1)]);
    issue_command(make_cmd(FUNC_TOGGLE, key));                   // delete on a full set
    issue_command(make_cmd(FUNC_TOGGLE, key));                   // full again
    issue_command(make_cmd(FUNC_TOGGLE, 32'(set_keys[0])));
    issue_command(make_cmd(FUNC_TOGGLE, absent_key()));
    issue_command(make_cmd(FUNC_TOGGLE, 32'(set_keys[SetDepth - 1])));
    issue_command(make_cmd(FUNC_TOGGLE, absent_key()));
    issue_command(make_cmd(FUNC_TOGGLE, absent_key()));          // refused again
    while (set_count > 0) begin
      key = 32'(set_keys[$urandom_range(set_count - 1)]);
      issue_command(make_cmd(FUNC_TOGGLE, key));
    end
  endtask

  // random walk of the set size; each block of 100 leans toward filling, draining or neither
  task automatic test_random();
    int unsigned lean_present;   // percent of commands aimed at a held key
    int unsigned pick;
    int unsigned key;
    sbs_func_e   func;
    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(2))
          0:       lean_present = 20;
          1:       lean_present = 80;
          default: lean_present = 50;
        endcase
      end
      quiet_stretch = (n >= 600 && n < 1000);
      func = ($urandom_range(99) < 35) ? FUNC_CHECK : FUNC_TOGGLE;
      pick = $urandom_range(99);
      if (set_count > 0 && $urandom_range(99) < lean_present) begin
        key = 32'(set_keys[$urandom_range(set_count - 1)]);
      end else if (pick < 30) begin
        key = $urandom_range(47);                  // dense low keys: neighbors and repeats
      end else if (pick < 35) begin
        key = $urandom_range(1) ? KeyMax : 0;
      end else begin
        key = $urandom_range(KeyMax);
      end
      issue_command(make_cmd(func, key));
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    set_count     = 0;
    mismatches    = 0;
    stall_cycles  = 0;
    quiet_stretch = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_full_set();
    test_random();

    // drain: stop issuing and wait for every owed beat
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[sorted_breakpoint_set_top] OK");
    end else begin
      $display("[sorted_breakpoint_set_top] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/sbs_pkg.sv
sv/sbs_cell.sv
sv/sorted_breakpoint_set_top.sv
tb/sv/tb_top.sv
